// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled away for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/ctfp_pkg.sv
// ---------------------------------------------------------------------------
// CRSF telemetry frame parser package
// Shared constants, the frame summary type and the CRC-8 fold function.
// ---------------------------------------------------------------------------
`default_nettype none

package ctfp_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int EXP_W           = 7;

    localparam logic [7:0] CRC_POLY      = 8'hD5;
    localparam logic [7:0] TYPE_LINK     = 8'h14;
    localparam logic [7:0] TYPE_BATTERY  = 8'h08;
    localparam logic [7:0] TYPE_GPS      = 8'h02;
    localparam logic [7:0] TYPE_AIRSPEED = 8'h0A;

    localparam logic [5:0] MAX_LEN_RESET = 6'd62;
    localparam logic [7:0] LEN_MIN       = 8'd2;
    localparam logic [EXP_W-1:0] LEN_OVERHEAD = 7'd2;

    // Smallest length bytes that carry the payload each update needs.
    localparam logic [5:0] LINK_MIN_LEN     = 6'd12;
    localparam logic [5:0] BATTERY_MIN_LEN  = 6'd10;
    localparam logic [5:0] GPS_MIN_LEN      = 6'd17;
    localparam logic [5:0] AIRSPEED_MIN_LEN = 6'd4;

    // Frame positions of the captured bytes.
    localparam int IDX_TYPE = 2;
    localparam int IDX_B3   = 3;
    localparam int IDX_B4   = 4;
    localparam int IDX_B5   = 5;
    localparam int IDX_B10  = 10;
    localparam int IDX_B11  = 11;
    localparam int IDX_B12  = 12;

    localparam logic [2:0] UPD_NONE     = 3'd0;
    localparam logic [2:0] UPD_LINK     = 3'd1;
    localparam logic [2:0] UPD_BATTERY  = 3'd2;
    localparam logic [2:0] UPD_GPS      = 3'd3;
    localparam logic [2:0] UPD_AIRSPEED = 3'd4;

    // Reciprocal of ten for a 16-bit dividend, applied with a 19-bit shift.
    localparam logic [15:0] RECIP_TEN = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic       good;
        logic [7:0] frame_type;
        logic [5:0] frame_length;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b10;
        logic [7:0] b11;
        logic [7:0] b12;
    } frame_t;

    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/ctfp_frame_tracker.sv
// ---------------------------------------------------------------------------
// CRSF frame tracker
// Follows the byte position within a frame, checks the length byte, runs the
// CRC-8 and captures the frame bytes that the telemetry decode needs.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ctfp_frame_tracker
    import ctfp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    input  wire logic [5:0] max_length,
    output frame_t          frm
);

    localparam int CW = $clog2(FRAME_BYTES + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [7:0]       crc_reg, crc_next;
    logic [5:0]       len_reg, len_next;
    logic [7:0]       type_reg, b3_reg, b4_reg, b5_reg, b10_reg, b11_reg, b12_reg;
    logic [CW-1:0]    c0, c1;
    logic [EXP_W-1:0] expect_len;
    logic             cap, good;

    always_comb
    begin
        c0         = (cnt_reg >= CW'(FRAME_BYTES)) ? '0 : cnt_reg;
        c1         = c0 + CW'(1);
        expect_len = EXP_W'(len_reg) + LEN_OVERHEAD;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        len_next   = len_reg;
        cap        = 1'b0;
        good       = 1'b0;
        if (step)
        begin
            priority if (c1 == CW'(2))
            begin
                if (rx_byte < LEN_MIN || rx_byte > {2'b00, max_length})
                begin
                    cnt_next = CW'(1);
                end
                else
                begin
                    cnt_next = c1;
                    crc_next = '0;
                    len_next = rx_byte[5:0];
                end
            end
            else if (c1 < CW'(2))
            begin
                cnt_next = c1;
            end
            else if (expect_len > EXP_W'(FRAME_BYTES))
            begin
                cnt_next = '0;
            end
            else if (EXP_W'(c1) < expect_len)
            begin
                cnt_next = c1;
                crc_next = crc8_fold(crc_reg, rx_byte);
                cap      = 1'b1;
            end
            else
            begin
                cnt_next = '0;
                good     = (crc_reg == rx_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            crc_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (cap)
        begin
            if (c0 == CW'(IDX_TYPE)) type_reg <= rx_byte;
            if (c0 == CW'(IDX_B3))   b3_reg   <= rx_byte;
            if (c0 == CW'(IDX_B4))   b4_reg   <= rx_byte;
            if (c0 == CW'(IDX_B5))   b5_reg   <= rx_byte;
            if (c0 == CW'(IDX_B10))  b10_reg  <= rx_byte;
            if (c0 == CW'(IDX_B11))  b11_reg  <= rx_byte;
            if (c0 == CW'(IDX_B12))  b12_reg  <= rx_byte;
        end
    end

    assign frm.good         = good;
    assign frm.frame_type   = type_reg;
    assign frm.frame_length = len_reg;
    assign frm.b3           = b3_reg;
    assign frm.b4           = b4_reg;
    assign frm.b5           = b5_reg;
    assign frm.b10          = b10_reg;
    assign frm.b11          = b11_reg;
    assign frm.b12          = b12_reg;

    `ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(FRAME_BYTES))
    `ASSERT_NEXT(a_good_restarts, clk, rst_n, frm.good, cnt_reg == '0)
    `ASSERT_IMPLY(a_good_needs_step, clk, rst_n, frm.good, step)

endmodule

`default_nettype wire

// File: sv/crsf_telemetry_frame_parser.sv
// ---------------------------------------------------------------------------
// CRSF telemetry frame parser
// Assembles received bytes into frames, checks the CRC-8 and keeps the
// decoded telemetry values.
// ---------------------------------------------------------------------------
// One received byte can be accepted in every clock cycle while in_stall is
// low. A byte is decoded while it sits in the input register, and the result
// of a good frame is written to the result register at the clock edge at
// which its CRC byte is stepped, so it passes the input register and then the
// result register before it is offered. Input bytes are held off only
// while a finished result sits in the result register and out_stall is high.
// Each good frame gives one result carrying the frame type, the length byte,
// the update code and all held telemetry values; bad frames and bytes inside
// a frame give none. The configured maximum length should be written only
// while no byte is in flight.
`default_nettype none
`include "assert_macros.svh"

module crsf_telemetry_frame_parser
    import ctfp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       frame_type,
    output logic [5:0]       frame_length,
    output logic [2:0]       update_code,
    output logic [7:0]       link_quality,
    output logic [15:0]      battery_voltage,
    output logic [7:0]       battery_remaining,
    output logic [12:0]      gps_speed,
    output logic [15:0]      airspeed,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data
);

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_byte_reg;
    logic        res_vld_reg, res_vld_next;
    logic [7:0]  type_reg;
    logic [5:0]  len_reg;
    logic [2:0]  code_reg, code_next;
    logic [7:0]  link_reg, link_next;
    logic [15:0] volt_reg, volt_next;
    logic [7:0]  remain_reg, remain_next;
    logic [12:0] gps_reg, gps_next;
    logic [15:0] air_reg, air_next;
    logic [5:0]  max_len_reg;
    logic        advance, step, in_take;
    logic [31:0] gps_prod;
    frame_t      frm;

    assign advance  = !(res_vld_reg && out_stall);
    assign step     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    ctfp_frame_tracker #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (in_byte_reg),
        .max_length (max_len_reg),
        .frm        (frm)
    );

    assign gps_prod = 32'({frm.b11, frm.b12}) * 32'(RECIP_TEN);

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        res_vld_next = advance ? (step && frm.good) : res_vld_reg;
    end

    always_comb
    begin
        code_next   = UPD_NONE;
        link_next   = link_reg;
        volt_next   = volt_reg;
        remain_next = remain_reg;
        gps_next    = gps_reg;
        air_next    = air_reg;
        priority if (frm.frame_type == TYPE_LINK)
        begin
            if (frm.frame_length >= LINK_MIN_LEN)
            begin
                link_next = frm.b5;
                code_next = UPD_LINK;
            end
        end
        else if (frm.frame_type == TYPE_BATTERY)
        begin
            if (frm.frame_length >= BATTERY_MIN_LEN)
            begin
                volt_next   = {frm.b3, frm.b4};
                remain_next = frm.b10;
                code_next   = UPD_BATTERY;
            end
        end
        else if (frm.frame_type == TYPE_GPS)
        begin
            if (frm.frame_length >= GPS_MIN_LEN)
            begin
                gps_next  = gps_prod[RECIP_SHIFT +: 13];
                code_next = UPD_GPS;
            end
        end
        else if (frm.frame_type == TYPE_AIRSPEED)
        begin
            if (frm.frame_length >= AIRSPEED_MIN_LEN)
            begin
                air_next  = {frm.b3, frm.b4};
                code_next = UPD_AIRSPEED;
            end
        end
        else
        begin
            code_next = UPD_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
            max_len_reg <= MAX_LEN_RESET;
            link_reg    <= '0;
            volt_reg    <= '0;
            remain_reg  <= '0;
            gps_reg     <= '0;
            air_reg     <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= cfg_data;
            end
            if (step && frm.good)
            begin
                link_reg   <= link_next;
                volt_reg   <= volt_next;
                remain_reg <= remain_next;
                gps_reg    <= gps_next;
                air_reg    <= air_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && frm.good)
        begin
            type_reg <= frm.frame_type;
            len_reg  <= frm.frame_length;
            code_reg <= code_next;
        end
    end

    assign out_valid         = res_vld_reg;
    assign frame_type        = type_reg;
    assign frame_length      = len_reg;
    assign update_code       = code_reg;
    assign link_quality      = link_reg;
    assign battery_voltage   = volt_reg;
    assign battery_remaining = remain_reg;
    assign gps_speed         = gps_reg;
    assign airspeed          = air_reg;

    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    `ASSERT_NEXT(a_good_gives_result, clk, rst_n, step && frm.good, out_valid)
    `ASSERT_IMPLY(a_gps_code_type, clk, rst_n, out_valid && update_code == UPD_GPS,
                  frame_type == TYPE_GPS && frame_length >= GPS_MIN_LEN)

endmodule

`default_nettype wire
